>>> rtl/core/grid_disk_conditional_fill_macros.svh
// assertion macros for the grid stamping block
// expects clk and rst_n in the scope where a macro is used
`ifndef GRID_DISK_CONDITIONAL_FILL_MACROS_SVH
`define GRID_DISK_CONDITIONAL_FILL_MACROS_SVH

// same-cycle implication, checked out of reset
`define GDCF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define GDCF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/gdcf_pkg.sv
// shared constants, command codes and controller/datapath structs
// for the grid stamping block; no dependencies
`timescale 1ns / 1ps

package gdcf_pkg;

  localparam int GRID_W     = 128;
  localparam int GRID_H     = 128;
  localparam int MAX_RADIUS = 63;

  localparam int DEPTH  = GRID_W * GRID_H;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(GRID_W);
  localparam int ROW_W  = $clog2(GRID_H);

  // field widths of the command and result items
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 10;
  localparam int RADIUS_W = 6;
  localparam int DATA_W   = 8;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 4;

  // stamp walk widths
  localparam int RAD_W = $clog2(MAX_RADIUS + 1);
  localparam int MAG_W = $clog2(MAX_RADIUS + 3);
  localparam int DX_W  = MAG_W + 1;
  localparam int DY_W  = $clog2(3 * MAX_RADIUS + 1) + 1;
  localparam int CRD_W = (DY_W > POS_W ? DY_W : POS_W) + 1;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 3'd0,
    FN_READ   = 3'd1,
    FN_DISK   = 3'd2,
    FN_STICKY = 3'd3,
    FN_FLOOD  = 3'd4
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMPTY_CODE = 4'd0,
    REG_FILL_CODE  = 4'd1,
    REG_STICKY_BIT = 4'd2,
    REG_TYPE_MASK  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic clear;
    logic capture;
    logic access;
    logic walk;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_stamp;
    logic walk_last;
    logic pipe_busy;
  } dp_sts_t;

endpackage

>>> rtl/core/grid_disk_conditional_fill.sv
// channel   dir  handshake              payload
// in_       in   in_tvalid/in_tready    tuser func, tdata x,y,radius,cell_data
// out_      out  out_tvalid/out_tready  tdata cell_value,in_bounds
// cfg_      in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// write, read and unused codes: the result is valid after the ACCESS and DONE states
// stamps: the walk covers (2f+1)*(h+1) cells, f the half width, h the box height,
//   one cell per cycle through the single read and single write memory port
// after reset a clear pass over all GRID_W*GRID_H cells (16384) runs before the
//   first command is taken; config writes are taken at any time
// a waiting result does not block the next command transfer
// top level of the grid stamping block; uses gdcf_pkg, gdcf_ctrl and gdcf_dp
`timescale 1ns / 1ps

module grid_disk_conditional_fill (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // center_x[9:0], center_y[19:10], radius[25:20], cell_data[33:26], zero pad
  input  logic [gdcf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // func[2:0]
  input  logic [gdcf_pkg::FUNC_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // cell_value[7:0], in_bounds[8], zero pad
  output logic [gdcf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gdcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gdcf_pkg::DATA_W-1:0]          cfg_data
);
  import gdcf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic [DATA_W-1:0] cell_value;
  logic              in_bounds;

  gdcf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gdcf_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_tuser),
    .in_center_x    (in_tdata[POS_W-1:0]),
    .in_center_y    (in_tdata[2*POS_W-1:POS_W]),
    .in_radius      (in_tdata[2*POS_W+RADIUS_W-1:2*POS_W]),
    .in_cell_data   (in_tdata[2*POS_W+RADIUS_W+DATA_W-1:2*POS_W+RADIUS_W]),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_cell_value (cell_value),
    .out_in_bounds  (in_bounds)
  );

  assign cfg_ready = 1'b1;
  assign out_tdata = {{(OUT_TDATA_W-DATA_W-1){1'b0}}, in_bounds, cell_value};

endmodule

>>> rtl/core/gdcf_ctrl.sv
// sequencer for the grid stamping block: clear pass, command steps,
// stamp walk and result hand-off; uses gdcf_pkg and the assertion macros
`timescale 1ns / 1ps
`include "grid_disk_conditional_fill_macros.svh"

module gdcf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gdcf_pkg::dp_cmd_t cmd,
  input  gdcf_pkg::dp_sts_t sts
);
  import gdcf_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ACCESS = 6'b000100,
    ST_STAMP  = 6'b001000,
    ST_DRAIN  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_vld_r, out_vld_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = sts.is_stamp ? ST_STAMP : ST_DONE;
      end
      ST_STAMP: begin
        cmd.walk = 1'b1;
        if (sts.walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        // wait for the last read-modify-write to retire
        if (!sts.pipe_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign out_vld_nxt = cmd.load_out | (out_vld_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_vld_r;

  `GDCF_ASSERT_IMP(a_load_free, cmd.load_out, !out_vld_r || out_ready, "result overwritten")
  `GDCF_ASSERT_IMP(a_accept_quiet, in_valid && in_ready, !sts.pipe_busy, "accept with busy pipe")
  `GDCF_ASSERT_NXT(a_walk_drain, (state_r == ST_STAMP) && sts.walk_last, state_r == ST_DRAIN, "walk did not end")

endmodule

>>> rtl/core/gdcf_dp.sv
// datapath of the grid stamping block: cell memory, config registers,
// stamp walk counters and the read-modify-write pipe; uses gdcf_pkg and macros
`timescale 1ns / 1ps
`include "grid_disk_conditional_fill_macros.svh"

module gdcf_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gdcf_pkg::dp_cmd_t                   cmd,
  output gdcf_pkg::dp_sts_t                   sts,
  input  logic [gdcf_pkg::FUNC_W-1:0]         in_func,
  input  logic signed [gdcf_pkg::POS_W-1:0]   in_center_x,
  input  logic signed [gdcf_pkg::POS_W-1:0]   in_center_y,
  input  logic [gdcf_pkg::RADIUS_W-1:0]       in_radius,
  input  logic [gdcf_pkg::DATA_W-1:0]         in_cell_data,
  input  logic                                cfg_valid,
  input  logic [gdcf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gdcf_pkg::DATA_W-1:0]         cfg_data,
  output logic [gdcf_pkg::DATA_W-1:0]         out_cell_value,
  output logic                                out_in_bounds
);
  import gdcf_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  logic [DATA_W-1:0] empty_code_r, fill_code_r, sticky_bit_r, type_mask_r;

  logic [FUNC_W-1:0]        func_r;
  logic signed [POS_W-1:0]  cmd_x_r, cmd_y_r;
  logic [DATA_W-1:0]        data_r, fill_val_r;
  logic [MAG_W-1:0]         fr_r;
  logic signed [DY_W-1:0]   dylo_r;
  logic                     flood_r;
  logic [2*MAG_W-1:0]       lim_r;
  logic signed [DX_W-1:0]   dx_r;
  logic signed [DY_W-1:0]   dy_r;

  logic [ADDR_W-1:0] clr_addr_r;
  logic              p1_vld_r, p2_vld_r;
  logic [ADDR_W-1:0] p1_addr_r, p2_addr_r;
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_inb_r;

  function automatic logic on_grid(input logic signed [CRD_W-1:0] x,
                                   input logic signed [CRD_W-1:0] y);
    return !x[CRD_W-1] && (x < CRD_W'(GRID_W)) && !y[CRD_W-1] && (y < CRD_W'(GRID_H));
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CRD_W-1:0] x,
                                                  input logic signed [CRD_W-1:0] y);
    return ADDR_W'(ADDR_W'(y[ROW_W-1:0]) * ADDR_W'(GRID_W)) + ADDR_W'(x[COL_W-1:0]);
  endfunction

  // ---- command capture
  logic [7:0]             rad8;
  logic [RAD_W-1:0]       r_sat;
  logic                   flood_in;
  logic [DY_W-1:0]        three_r;
  logic [MAG_W-1:0]       fr_in;
  logic signed [DY_W-1:0] dylo_in;

  assign rad8     = 8'(in_radius);
  assign r_sat    = (rad8 > 8'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(in_radius);
  assign flood_in = (in_func == FN_FLOOD);
  assign three_r  = DY_W'({r_sat, 1'b0}) + DY_W'(r_sat);
  assign fr_in    = flood_in ? MAG_W'(r_sat) + MAG_W'(2) : MAG_W'(r_sat);
  assign dylo_in  = flood_in ? -three_r : -DY_W'(r_sat);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r     <= in_func;
      cmd_x_r    <= in_center_x;
      cmd_y_r    <= in_center_y;
      data_r     <= in_cell_data;
      fr_r       <= fr_in;
      dylo_r     <= dylo_in;
      flood_r    <= flood_in;
      fill_val_r <= (in_func == FN_STICKY) ? (fill_code_r | sticky_bit_r) : fill_code_r;
    end
  end

  // ---- config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_code_r <= 8'd0;
      fill_code_r  <= 8'd1;
      sticky_bit_r <= 8'd128;
      type_mask_r  <= 8'd127;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EMPTY_CODE: empty_code_r <= cfg_data;
        REG_FILL_CODE:  fill_code_r  <= cfg_data;
        REG_STICKY_BIT: sticky_bit_r <= cfg_data;
        REG_TYPE_MASK:  type_mask_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- single cell access
  logic signed [CRD_W-1:0] cx_ext, cy_ext;
  logic                    cmd_inb, func_ok, cmd_we;
  logic [ADDR_W-1:0]       cmd_addr;

  assign cx_ext   = CRD_W'(cmd_x_r);
  assign cy_ext   = CRD_W'(cmd_y_r);
  assign cmd_inb  = on_grid(cx_ext, cy_ext);
  assign cmd_addr = cell_addr(cx_ext, cy_ext);
  assign cmd_we   = cmd.access && (func_r == FN_WRITE) && cmd_inb;

  always_comb begin
    case (func_r)
      FN_WRITE, FN_READ, FN_DISK, FN_STICKY, FN_FLOOD: func_ok = 1'b1;
      default:                                         func_ok = 1'b0;
    endcase
  end

  // ---- stamp walk over the bounding box, one cell per cycle
  logic signed [DX_W-1:0]  fr_dx, dx_abs;
  logic signed [DY_W-1:0]  fr_dy, dy_abs;
  logic [MAG_W-1:0]        dx_mag, vy_mag;
  logic [2*MAG_W-1:0]      dx_sq, vy_sq;
  logic [2*MAG_W:0]        sq_sum;
  logic                    dy_pos, covered;
  logic signed [CRD_W-1:0] wx, wy;
  logic                    walk_hit;

  assign fr_dx  = DX_W'({1'b0, fr_r});
  assign fr_dy  = DY_W'({1'b0, fr_r});
  assign dx_abs = dx_r[DX_W-1] ? -dx_r : dx_r;
  assign dy_abs = dy_r[DY_W-1] ? -dy_r : dy_r;
  assign dy_pos = !dy_r[DY_W-1] && (dy_r != '0);
  assign dx_mag = dx_abs[MAG_W-1:0];
  // the flood shape ignores the vertical offset of rows above the centre
  assign vy_mag = flood_r ? (dy_pos ? dy_r[MAG_W-1:0] : '0) : dy_abs[MAG_W-1:0];
  assign dx_sq  = dx_mag * dx_mag;
  assign vy_sq  = vy_mag * vy_mag;
  assign sq_sum = (2*MAG_W+1)'(dx_sq) + (2*MAG_W+1)'(vy_sq);
  assign covered = (sq_sum <= (2*MAG_W+1)'(lim_r));
  assign wx = cx_ext + CRD_W'(dx_r);
  assign wy = cy_ext + CRD_W'(dy_r);
  assign walk_hit = cmd.walk && covered && on_grid(wx, wy);

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      dx_r  <= -fr_dx;
      dy_r  <= dylo_r;
      lim_r <= fr_r * fr_r;
    end else if (cmd.walk) begin
      if (dx_r == fr_dx) begin
        dx_r <= -fr_dx;
        dy_r <= dy_r + DY_W'(1);
      end else begin
        dx_r <= dx_r + DX_W'(1);
      end
    end
  end

  // ---- read-modify-write pipe and clear sweep
  logic              stamp_we, wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data;

  assign stamp_we = p2_vld_r && ((rd_data_r & type_mask_r) == empty_code_r);
  assign rd_addr  = p1_vld_r ? p1_addr_r : cmd_addr;

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = p2_addr_r;
    wr_data = fill_val_r;
    if (cmd.clear) begin
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (cmd_we) begin
      wr_addr = cmd_addr;
      wr_data = data_r;
    end else if (!stamp_we) begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      p1_vld_r   <= 1'b0;
      p2_vld_r   <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr_r <= clr_addr_r + ADDR_W'(1);
      p1_vld_r <= walk_hit;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr_r <= cell_addr(wx, wy);
    p2_addr_r <= p1_addr_r;
  end

  // ---- result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_value_r <= ((func_r == FN_READ) && cmd_inb) ? rd_data_r : '0;
      out_inb_r   <= cmd_inb && func_ok;
    end
  end

  assign out_cell_value = out_value_r;
  assign out_in_bounds  = out_inb_r;

  assign sts.clr_last  = (clr_addr_r == ADDR_W'(DEPTH - 1));
  assign sts.is_stamp  = (func_r == FN_DISK) || (func_r == FN_STICKY) || (func_r == FN_FLOOD);
  assign sts.walk_last = (dx_r == fr_dx) && (dy_r == fr_dy);
  assign sts.pipe_busy = p1_vld_r || p2_vld_r;

  `GDCF_ASSERT_IMP(a_p2_from_p1, p2_vld_r, $past(p1_vld_r), "pipe stage skipped")
  `GDCF_ASSERT_IMP(a_p1_from_walk, p1_vld_r, $past(cmd.walk), "cell issued outside walk")
  `GDCF_ASSERT_IMP(a_clear_quiet, cmd.clear, !p1_vld_r && !p2_vld_r, "stamp during clear")

endmodule
